// ===== rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file, which checks itself.
// No dependencies; every macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/gbp_pkg.sv =====
// Shared types and constants for the gshare branch predictor.
// No dependencies.
package gbp_pkg;

	localparam int PC_W       = 48;
	localparam int CNT_W      = 32;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 72;
	localparam int CTR_W      = 2;
	localparam int PADDR_W    = 2;

	localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN   = 2'd2;
	localparam logic [CTR_W-1:0] CTR_STRONG_TAKEN = 2'd3;
	localparam logic [CTR_W-1:0] CTR_STRONG_NOT   = 2'd0;
	localparam logic [CNT_W-1:0] COUNT_MAX        = '1;

	localparam logic CMD_PREDICT = 1'b0;
	localparam logic CMD_UPDATE  = 1'b1;

	localparam logic MODE_ALWAYS_TAKEN = 1'b0;
	localparam logic MODE_GSHARE       = 1'b1;

	localparam logic [PADDR_W-1:0] REG_POLICY_MODE = 2'd0;

	// Controller commands to the datapath
	typedef struct packed {
		logic clr_wr;   // write one table entry of the reset sweep
		logic load_in;  // capture the input transaction, launch table read
		logic commit;   // update state, load output register
	} gbp_cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic clr_last; // sweep is at the last table entry
		logic out_busy; // output register holds a result not taken this cycle
	} gbp_sts_t;

endpackage

// ===== rtl/gbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/gbp_ctrl.sv =====
// Controller state machine: reset sweep, input capture, commit.
// Depends on gbp_pkg.
module gbp_ctrl
	import gbp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  gbp_sts_t sts,
	output logic     s_tready,
	output gbp_cmd_t cmd,
	output logic     clearing
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EVAL  = 3'b100
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.clr_wr  = 1'b0;
		cmd.load_in = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// wait until the output register can take the result
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign clearing = (state_q == ST_CLEAR);

endmodule

// ===== rtl/gbp_dp.sv =====
// Datapath: config register, pattern table, history, counts, output register.
// Depends on gbp_pkg and gbp_ram.
module gbp_dp
	import gbp_pkg::*;
#(
	parameter int HISTORY_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config write/read
	input  logic                 cfg_wr,
	input  logic [PADDR_W-1:0]   cfg_addr,
	input  logic [31:0]          cfg_wdata,
	output logic [31:0]          cfg_rdata,
	// input transaction
	input  logic                 in_cmd,
	input  logic [S_TDATA_W-1:0] in_data,
	// output transaction
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [M_TDATA_W-1:0] m_tdata,
	// controller link
	input  gbp_cmd_t             cmd,
	output gbp_sts_t             sts
);

	localparam int DEPTH = 1 << HISTORY_BITS;

	logic                    mode_q;
	logic [HISTORY_BITS-1:0] hist_q;
	logic [HISTORY_BITS-1:0] clr_q;
	logic [HISTORY_BITS-1:0] idx_q;
	logic                    cmd_q;
	logic                    pred_q;
	logic                    taken_q;
	logic [CNT_W-1:0]        brn_q;
	logic [CNT_W-1:0]        mis_q;
	logic                    guess_q;
	logic                    ovld_q;

	logic [HISTORY_BITS-1:0] rd_idx;
	logic [CTR_W-1:0]        ctr_rd;
	logic [CTR_W-1:0]        ctr_new;
	logic                    tbl_we;
	logic [HISTORY_BITS-1:0] tbl_waddr;
	logic [CTR_W-1:0]        tbl_wdata;
	logic                    upd;
	logic                    guess;
	logic [HISTORY_BITS:0]   hist_sh;

	// policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GSHARE;
		end else if (cfg_wr && cfg_addr == REG_POLICY_MODE) begin
			mode_q <= cfg_wdata[0];
		end
	end

	assign cfg_rdata = (cfg_addr == REG_POLICY_MODE) ? {31'd0, mode_q} : 32'd0;

	// table sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_q == {HISTORY_BITS{1'b1}});

	// index of the incoming item
	assign rd_idx = in_data[HISTORY_BITS-1:0] ^ hist_q;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			idx_q   <= rd_idx;
			cmd_q   <= in_cmd;
			pred_q  <= in_data[PC_W];
			taken_q <= in_data[PC_W+1];
		end
	end

	// saturating counter step
	always_comb begin
		ctr_new = ctr_rd;
		if (taken_q) begin
			if (ctr_rd != CTR_STRONG_TAKEN) begin
				ctr_new = ctr_rd + 1'b1;
			end
		end else begin
			if (ctr_rd != CTR_STRONG_NOT) begin
				ctr_new = ctr_rd - 1'b1;
			end
		end
	end

	assign upd = cmd.commit && (cmd_q == CMD_UPDATE);

	// table write port: sweep or update
	assign tbl_we    = cmd.clr_wr || (upd && mode_q == MODE_GSHARE);
	assign tbl_waddr = cmd.clr_wr ? clr_q : idx_q;
	assign tbl_wdata = cmd.clr_wr ? CTR_WEAK_TAKEN : ctr_new;

	gbp_ram #(
		.WIDTH(CTR_W),
		.DEPTH(DEPTH)
	) u_tbl (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re   (cmd.load_in),
		.raddr(rd_idx),
		.rdata(ctr_rd)
	);

	// global history: shift the outcome in, drop the oldest bit
	assign hist_sh = {hist_q, taken_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (upd && mode_q == MODE_GSHARE) begin
			hist_q <= hist_sh[HISTORY_BITS-1:0];
		end
	end

	// branch and misprediction counts, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brn_q <= '0;
			mis_q <= '0;
		end else if (upd) begin
			if (brn_q != COUNT_MAX) begin
				brn_q <= brn_q + 1'b1;
			end
			if (pred_q != taken_q && mis_q != COUNT_MAX) begin
				mis_q <= mis_q + 1'b1;
			end
		end
	end

	// prediction
	always_comb begin
		guess = 1'b0;
		if (cmd_q == CMD_PREDICT) begin
			guess = (mode_q == MODE_ALWAYS_TAKEN) ? 1'b1 : ctr_rd[CTR_W-1];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			guess_q <= guess;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (cmd.commit) begin
			ovld_q <= 1'b1;
		end else if (m_tready) begin
			ovld_q <= 1'b0;
		end
	end

	assign sts.out_busy = ovld_q && !m_tready;
	assign m_tvalid     = ovld_q;
	assign m_tdata      = {7'd0, mis_q, brn_q, guess_q};

endmodule

// ===== rtl/gshare_branch_predictor_core.sv =====
// Gshare branch predictor with 2-bit saturating counters, top level.
// Depends on gbp_pkg, gbp_ctrl, gbp_dp, gbp_ram and assert_macros.svh.
//
// Input stream (s_*): tuser is cmd (0 predict, 1 update); tdata carries pc,
// predicted_taken and outcome_taken. Output stream (m_*): one transaction per
// input transaction with predict_taken and both saturating counts.
// APB port: register 0 (byte address 0) is policy_mode, 0 always taken,
// 1 gshare; reset value 1. pready is always high.
//
// Flow: the pattern table read for an accepted transaction is registered, and
// the result is then committed to the output register; a new transaction is
// accepted only after that commit, so the write-back lands before the next read.
// Reset: history and counts clear at once; the table is then swept to weak
// taken, one entry per cycle, over all 2^HISTORY_BITS entries (4096 by default),
// with s_tready low. APB writes are taken during the sweep.
// Stall: a result held by m_tready low stays put; one more transaction may be
// accepted and waits until the output register frees.
`include "assert_macros.svh"
module gshare_branch_predictor_core
	import gbp_pkg::*;
#(
	parameter int HISTORY_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// APB configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [47:0] pc, [48] predicted_taken,
	                                       // [49] outcome_taken, [55:50] zero
	input  logic                 s_tuser,  // [0] cmd
	// output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // [0] predict_taken, [32:1] branch_count,
	                                       // [64:33] mispredict_count, [71:65] zero
);

	gbp_cmd_t cmd;
	gbp_sts_t sts;
	logic     clearing;
	logic     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	gbp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.sts     (sts),
		.s_tready(s_tready),
		.cmd     (cmd),
		.clearing(clearing)
	);

	gbp_dp #(
		.HISTORY_BITS(HISTORY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_addr (paddr),
		.cfg_wdata(pwdata),
		.cfg_rdata(prdata),
		.in_cmd   (s_tuser),
		.in_data  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	// no input taken while the table sweep runs
	`AST_IMPL(a_no_accept_in_clear, clearing, !s_tready)
	// one item at a time: after an accept, the next cycle evaluates it
	`AST_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	// every commit leaves a result on the output
	`AST_NEXT(a_commit_shows, cmd.commit, m_tvalid)
	// commands never overlap
	`AST_IMPL(a_cmd_excl, 1'b1, $onehot0({cmd.clr_wr, cmd.load_in, cmd.commit}))

endmodule

// ===== bench/gshare_branch_predictor_core_tb.sv =====
// Self-checking bench for the gshare branch predictor core: directed table, then random phases.
// Depends on gbp_pkg and the gshare_branch_predictor_core RTL; its own predictor checks each result.
module gshare_branch_predictor_core_tb;
	import gbp_pkg::*;

	localparam int HIST_W        = 12;
	localparam int TABLE_DEPTH   = 1 << HIST_W;
	localparam int RANDOM_ITEMS  = 552;
	localparam int PHASES        = 6;
	localparam int DIRECTED_ROWS = 21;
	localparam int MAX_REPORTS   = 10;

	// One input transaction
	typedef struct packed {
		logic            cmd;
		logic [PC_W-1:0] pc;
		logic            pred;
		logic            outc;
	} branch_op_t;

	// One output transaction
	typedef struct packed {
		logic             taken;
		logic [CNT_W-1:0] branches;
		logic [CNT_W-1:0] misses;
	} verdict_t;

	// Directed row: optional mode write first, optional typed-in result
	typedef struct packed {
		logic             set_mode;
		logic             mode_val;
		logic             typed;
		logic             cmd;
		logic [PC_W-1:0]  pc;
		logic             pred;
		logic             outc;
		logic             want_taken;
		logic [CNT_W-1:0] want_branches;
		logic [CNT_W-1:0] want_misses;
	} row_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [PADDR_W-1:0]   paddr    = '0;
	logic [31:0]          pwdata   = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0; // [47:0] pc, [48] predicted_taken, [49] outcome_taken
	logic                 s_tuser  = 1'b0; // [0] cmd
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata; // [0] predict_taken, [32:1] branch_count, [64:33] mispredict_count

	// Predictor state
	logic [CTR_W-1:0]  counter_table [TABLE_DEPTH];
	logic [HIST_W-1:0] path_history = '0;
	logic [CNT_W-1:0]  branch_total = '0;
	logic [CNT_W-1:0]  miss_total   = '0;
	logic              policy       = MODE_GSHARE;

	verdict_t        pending_verdicts [$];
	int              error_count   = 0;
	int              verdicts_seen = 0;
	int              mode_writes   = 0;
	int              random_sent   = 0;
	bit              steady        = 1'b0; // no idling on either side
	logic [PC_W-1:0] hot_pcs [16];

	logic phase_policy [PHASES] = '{MODE_GSHARE, MODE_ALWAYS_TAKEN, MODE_GSHARE,
		MODE_GSHARE, MODE_ALWAYS_TAKEN, MODE_GSHARE};

	row_t directed_rows [DIRECTED_ROWS] = '{
		// fresh table: weak taken everywhere, counts zero
		'{0, 0, 1, CMD_PREDICT, 48'h0,              0, 0, 1, 0, 0},
		'{0, 0, 1, CMD_PREDICT, 48'hFFFF_FFFF_FFFF, 1, 1, 1, 0, 0},
		// walk entry 0 down to strong not-taken and hold it there
		'{0, 0, 1, CMD_UPDATE,  48'h0,              1, 0, 0, 1, 1},
		'{0, 0, 1, CMD_PREDICT, 48'h0,              0, 0, 0, 1, 1},
		'{0, 0, 1, CMD_UPDATE,  48'h0,              0, 0, 0, 2, 1},
		'{0, 0, 1, CMD_UPDATE,  48'h0,              0, 0, 0, 3, 1},
		'{0, 0, 1, CMD_PREDICT, 48'h0,              1, 1, 0, 3, 1},
		// high pc bits do not reach the index
		'{0, 0, 1, CMD_UPDATE,  48'hFFFF_FFFF_F000, 1, 1, 0, 4, 1},
		// history now nonzero: follow entry 0 up to saturation
		'{0, 0, 0, CMD_UPDATE,  48'h1,              1, 1, 0, 0, 0},
		'{0, 0, 0, CMD_UPDATE,  48'h3,              1, 1, 0, 0, 0},
		'{0, 0, 0, CMD_UPDATE,  48'h7,              1, 1, 0, 0, 0},
		'{0, 0, 0, CMD_PREDICT, 48'hF,              0, 0, 0, 0, 0},
		'{0, 0, 0, CMD_UPDATE,  48'hFFF,            0, 1, 0, 0, 0},
		'{0, 0, 0, CMD_PREDICT, 48'h8000_0000_0ABC, 1, 0, 0, 0, 0},
		// always-taken: updates only count, table and history frozen
		'{1, MODE_ALWAYS_TAKEN, 0, CMD_PREDICT, 48'h0, 0, 0, 0, 0, 0},
		'{0, 0, 0, CMD_UPDATE,  48'h0,              1, 0, 0, 0, 0},
		'{0, 0, 0, CMD_UPDATE,  48'hFFFF_FFFF_FFFF, 0, 1, 0, 0, 0},
		'{0, 0, 0, CMD_PREDICT, 48'h123,            0, 0, 0, 0, 0},
		// back to gshare: contents kept across the switch
		'{1, MODE_GSHARE, 0, CMD_PREDICT, 48'hF,    0, 0, 0, 0, 0},
		'{0, 0, 0, CMD_UPDATE,  48'hF,              1, 0, 0, 0, 0},
		'{0, 0, 0, CMD_PREDICT, 48'h5555_AAAA_5555, 1, 1, 0, 0, 0}
	};

	gshare_branch_predictor_core #(
		.HISTORY_BITS(HIST_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// Run limit
	initial begin
		#400000;
		$display("gshare_branch_predictor_core_tb: errors");
		$finish;
	end

	function automatic int idle_draw();
		return steady ? 0 : $urandom_range(0, 12);
	endfunction

	// Direction the table gives for pc right now, no state change
	function automatic logic lookup_direction(logic [PC_W-1:0] pc);
		if (policy == MODE_ALWAYS_TAKEN)
			return 1'b1;
		return counter_table[pc[HIST_W-1:0] ^ path_history] >= CTR_WEAK_TAKEN;
	endfunction

	// Predict or train, advancing the predictor state; returns the result
	function automatic verdict_t resolve_branch(branch_op_t op);
		verdict_t          v;
		logic [HIST_W-1:0] idx;
		logic [CTR_W-1:0]  ctr;
		idx     = op.pc[HIST_W-1:0] ^ path_history;
		v.taken = 1'b0;
		if (op.cmd == CMD_PREDICT) begin
			v.taken = lookup_direction(op.pc);
		end else begin
			if (branch_total != COUNT_MAX)
				branch_total = branch_total + 1'b1;
			if (op.pred != op.outc && miss_total != COUNT_MAX)
				miss_total = miss_total + 1'b1;
			if (policy == MODE_GSHARE) begin
				ctr = counter_table[idx];
				if (op.outc && ctr != CTR_STRONG_TAKEN)
					ctr = ctr + 1'b1;
				else if (!op.outc && ctr != CTR_STRONG_NOT)
					ctr = ctr - 1'b1;
				counter_table[idx] = ctr;
				path_history = {path_history[HIST_W-2:0], op.outc};
			end
		end
		v.branches = branch_total;
		v.misses   = miss_total;
		return v;
	endfunction

	task automatic note_error(string what, verdict_t want, verdict_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%s: want taken=%0b br=%0d miss=%0d, got taken=%0b br=%0d miss=%0d",
				what, want.taken, want.branches, want.misses,
				got.taken, got.branches, got.misses);
	endtask

	// Send one transaction; valid stays high afterwards until the next call decides
	task automatic send_branch_op(branch_op_t op, logic typed, verdict_t want);
		int       gap;
		verdict_t v;
		gap = idle_draw();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op.cmd;
		s_tdata  <= {{(S_TDATA_W-PC_W-2){1'b0}}, op.outc, op.pred, op.pc};
		do @(posedge clk); while (!s_tready);
		v = resolve_branch(op);
		pending_verdicts.push_back(typed ? want : v);
	endtask

	// Drop valid and wait until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic apb_cycle(logic wr, logic [31:0] data, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REG_POLICY_MODE;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Write policy_mode (block idle) and read it back
	task automatic set_policy(logic mode);
		logic [31:0] rd;
		drain();
		apb_cycle(1'b1, {31'b0, mode}, rd);
		policy = mode;
		mode_writes++;
		@(posedge clk);
		apb_cycle(1'b0, '0, rd);
		if (rd !== {31'b0, policy}) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("policy_mode readback: want %0b, got %0h", policy, rd);
		end
	endtask

	// Result side: random stall per transaction
	initial begin
		int stall;
		forever begin
			stall = idle_draw();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Result checker
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.taken    = m_tdata[0];
			got.branches = m_tdata[32:1];
			got.misses   = m_tdata[64:33];
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				note_error("result with nothing pending", '0, got);
			end else begin
				want = pending_verdicts.pop_front();
				if (got !== want)
					note_error("result mismatch", want, got);
			end
		end
	end

	// Stimulus
	initial begin
		branch_op_t op;
		verdict_t   want;
		logic [31:0] rd;
		int         kind;
		int         slot;
		for (int i = 0; i < TABLE_DEPTH; i++)
			counter_table[i] = CTR_WEAK_TAKEN;
		for (int i = 0; i < 16; i++)
			hot_pcs[i] = PC_W'({$urandom(), $urandom()});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of policy_mode
		apb_cycle(1'b0, '0, rd);
		if (rd !== {31'b0, MODE_GSHARE}) begin
			error_count++;
			$display("policy_mode after reset: want %0b, got %0h", MODE_GSHARE, rd);
		end

		// Directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_mode)
				set_policy(directed_rows[i].mode_val);
			op   = '{directed_rows[i].cmd, directed_rows[i].pc,
				directed_rows[i].pred, directed_rows[i].outc};
			want = '{directed_rows[i].want_taken, directed_rows[i].want_branches,
				directed_rows[i].want_misses};
			send_branch_op(op, directed_rows[i].typed, want);
		end

		// Random phases; mostly predict/update pairs on a small set of hot branches
		for (int p = 0; p < PHASES; p++) begin
			set_policy(phase_policy[p]);
			steady = (p == 3);
			while (random_sent < (p + 1) * RANDOM_ITEMS / PHASES) begin
				kind = $urandom_range(0, 9);
				slot = $urandom_range(0, 15);
				op.pc = ($urandom_range(0, 3) != 0) ? hot_pcs[slot]
					: PC_W'({$urandom(), $urandom()});
				if (kind <= 5) begin
					// pair: prediction, then resolve with the prediction given
					op.cmd  = CMD_PREDICT;
					op.pred = 1'($urandom_range(0, 1));
					op.outc = 1'($urandom_range(0, 1));
					send_branch_op(op, 1'b0, '0);
					op.cmd  = CMD_UPDATE;
					op.pred = lookup_direction(op.pc);
					if (slot < 8)
						op.outc = (slot[0] == 1'b0) ? ($urandom_range(0, 7) != 0)
							: ($urandom_range(0, 7) == 0);
					else
						op.outc = 1'($urandom_range(0, 1));
					send_branch_op(op, 1'b0, '0);
					random_sent += 2;
				end else begin
					op.cmd  = (kind <= 7) ? CMD_UPDATE : CMD_PREDICT;
					op.pred = 1'($urandom_range(0, 1));
					op.outc = 1'($urandom_range(0, 1));
					send_branch_op(op, 1'b0, '0);
					random_sent++;
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("%0d directed rows and %0d random transactions, %0d results checked",
			DIRECTED_ROWS, random_sent, verdicts_seen);
		$display("%0d policy_mode writes, final counts: %0d branches, %0d mispredictions",
			mode_writes, branch_total, miss_total);
		if (error_count == 0 && pending_verdicts.size() == 0) begin
			$display("gshare_branch_predictor_core_tb: clean");
		end else begin
			$display("gshare_branch_predictor_core_tb: errors");
		end
		$finish;
	end

endmodule
